// ----- rtl/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache with TTL aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int DEF_TABLE_ENTRIES = 16;

	localparam logic [31:0] BCAST_IP          = 32'hFFFF_FFFF;
	localparam logic [47:0] BCAST_MAC         = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] DEFAULT_LEARN_TTL = 32'd180000;
	localparam logic [15:0] MIN_FRAME_BYTES   = 16'd42;
	localparam logic [15:0] ARP_OP_REQ        = 16'd1;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_TICK   = 2'd2,
		OP_PACKET = 2'd3
	} arpc_op_t;

	localparam logic [1:0] CFG_LOCAL_IP      = 2'd0;
	localparam logic [1:0] CFG_REPLY_ENABLED = 2'd1;
	localparam logic [1:0] CFG_LEARN_TTL     = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;    // latch a new request
		logic rd_en;   // read table entry at the scan index
		logic age;     // current request is a tick
		logic commit;  // write the put or learned entry
		logic emit;    // capture the result
	} arpc_cmd_t;

endpackage

// ----- rtl/arpc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// Controller: accepts requests, walks the table index and sequences the
// final write and the result strobe.
// ----------------------------------------------------------------------------
module arpc_ctrl import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       opcode,
	input  logic [15:0]      frame_length,
	output logic             busy,
	output logic             done,
	output arpc_cmd_t        cmd,
	output logic [IDX_W-1:0] rd_idx
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	arpc_op_t         op_q;
	logic             wr_q;
	logic             busy_q;
	logic             done_q;
	logic             accept;
	logic             do_write;

	assign accept   = start && !busy_q;
	// put always writes, a packet only when the frame is long enough
	assign do_write = (arpc_op_t'(opcode) == OP_PUT) ||
		((arpc_op_t'(opcode) == OP_PACKET) && (frame_length >= MIN_FRAME_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			op_q    <= OP_PUT;
			wr_q    <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						op_q    <= arpc_op_t'(opcode);
						wr_q    <= do_write;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && accept;
		cmd.rd_en  = (state_q == ST_SCAN);
		cmd.age    = (op_q == OP_TICK);
		cmd.commit = (state_q == ST_FINISH) && wr_q;
		cmd.emit   = (state_q == ST_FINISH);
	end

	assign rd_idx = cnt_q;
	assign busy   = busy_q;
	assign done   = done_q;

endmodule

// ----- rtl/arpc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_dp
// Datapath: table memories with per-entry valid bits, request and
// configuration registers, search flags, aging write-back and result regs.
// ----------------------------------------------------------------------------
module arpc_dp import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  arpc_cmd_t        cmd,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [31:0]      cfg_data,
	input  logic [1:0]       opcode,
	input  logic [31:0]      ip_addr,
	input  logic [47:0]      mac_addr,
	input  logic [31:0]      time_ms,
	input  logic             static_flag,
	input  logic [15:0]      arp_operation,
	input  logic [31:0]      dest_ip,
	input  logic [15:0]      frame_length,
	output logic             hit,
	output logic [47:0]      found_mac,
	output logic             send_reply,
	output logic [31:0]      reply_ip,
	output logic [47:0]      reply_mac
);

	// table storage, no reset; ent_valid_q marks entries written since reset
	logic [31:0] mem_ip    [TABLE_ENTRIES];
	logic [47:0] mem_mac   [TABLE_ENTRIES];
	logic [31:0] mem_ttl   [TABLE_ENTRIES];
	logic        mem_fixed [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] ent_valid_q;

	// configuration
	logic [31:0] local_ip_q;
	logic        reply_en_q;
	logic [31:0] learn_ttl_q;

	// request
	arpc_op_t    op_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [31:0] time_q;
	logic        static_q;
	logic [15:0] aop_q;
	logic [31:0] tip_q;
	logic [15:0] flen_q;

	// read stage
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [31:0]      rd_ip_s1;
	logic [47:0]      rd_mac_s1;
	logic [31:0]      rd_ttl_s1;
	logic             rd_fixed_s1;

	// search results
	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [47:0]      match_mac_q;
	logic             zero_found_q;
	logic [IDX_W-1:0] zero_idx_q;

	// results
	logic        hit_q;
	logic [47:0] found_mac_q;
	logic        send_reply_q;
	logic [31:0] reply_ip_q;
	logic [47:0] reply_mac_q;

	logic        cur_ip0;
	logic [31:0] cur_ip;
	logic [47:0] cur_mac;
	logic [31:0] cur_ttl;
	logic        cur_fixed;
	logic        age_wr;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [31:0]      wr_ip;
	logic [47:0]      wr_mac;
	logic [31:0]      wr_ttl;
	logic             wr_fixed;
	logic             reply_due;

	// entry as seen at reset when never written: broadcast at entry 0
	always_comb begin
		cur_ip0 = (rd_idx_s1 == '0);
		if (ent_valid_q[rd_idx_s1]) begin
			cur_ip    = rd_ip_s1;
			cur_mac   = rd_mac_s1;
			cur_ttl   = rd_ttl_s1;
			cur_fixed = rd_fixed_s1;
		end else begin
			cur_ip    = cur_ip0 ? BCAST_IP : '0;
			cur_mac   = cur_ip0 ? BCAST_MAC : '0;
			cur_ttl   = '0;
			cur_fixed = cur_ip0;
		end
	end

	assign age_wr = rd_vld_s1 && cmd.age && (cur_ip != '0) && !cur_fixed;

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = rd_idx_s1;
		wr_ip    = '0;
		wr_mac   = '0;
		wr_ttl   = '0;
		wr_fixed = 1'b0;
		if (age_wr) begin
			wr_en = 1'b1;
			if (cur_ttl > time_q) begin
				wr_ip  = cur_ip;
				wr_mac = cur_mac;
				wr_ttl = cur_ttl - time_q;
			end
		end else if (cmd.commit) begin
			wr_en  = 1'b1;
			wr_idx = match_found_q ? match_idx_q : (zero_found_q ? zero_idx_q : '0);
			wr_ip  = ip_q;
			wr_mac = mac_q;
			if (op_q == OP_PUT) begin
				wr_ttl   = static_q ? '0 : time_q;
				wr_fixed = static_q;
			end else begin
				wr_ttl = learn_ttl_q;
			end
		end
	end

	assign reply_due = (op_q == OP_PACKET) && (flen_q >= MIN_FRAME_BYTES) &&
		(aop_q == ARP_OP_REQ) && (tip_q == local_ip_q) &&
		(local_ip_q != '0) && reply_en_q;

	// memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_ip[wr_idx]    <= wr_ip;
			mem_mac[wr_idx]   <= wr_mac;
			mem_ttl[wr_idx]   <= wr_ttl;
			mem_fixed[wr_idx] <= wr_fixed;
		end
		if (cmd.rd_en) begin
			rd_ip_s1    <= mem_ip[rd_idx];
			rd_mac_s1   <= mem_mac[rd_idx];
			rd_ttl_s1   <= mem_ttl[rd_idx];
			rd_fixed_s1 <= mem_fixed[rd_idx];
		end
	end

	// request, search and result payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx;
		if (cmd.load) begin
			op_q     <= arpc_op_t'(opcode);
			ip_q     <= ip_addr;
			mac_q    <= mac_addr;
			time_q   <= time_ms;
			static_q <= static_flag;
			aop_q    <= arp_operation;
			tip_q    <= dest_ip;
			flen_q   <= frame_length;
		end
		if (rd_vld_s1 && !match_found_q && (cur_ip == ip_q)) begin
			match_idx_q <= rd_idx_s1;
			match_mac_q <= cur_mac;
		end
		if (rd_vld_s1 && !zero_found_q && (cur_ip == '0)) begin
			zero_idx_q <= rd_idx_s1;
		end
		if (cmd.emit) begin
			hit_q        <= (op_q == OP_LOOKUP) && match_found_q;
			found_mac_q  <= ((op_q == OP_LOOKUP) && match_found_q) ? match_mac_q : '0;
			send_reply_q <= reply_due;
			reply_ip_q   <= reply_due ? ip_q : '0;
			reply_mac_q  <= reply_due ? mac_q : '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q   <= '0;
			rd_vld_s1     <= 1'b0;
			match_found_q <= 1'b0;
			zero_found_q  <= 1'b0;
			local_ip_q    <= '0;
			reply_en_q    <= 1'b0;
			learn_ttl_q   <= DEFAULT_LEARN_TTL;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (wr_en) begin
				ent_valid_q[wr_idx] <= 1'b1;
			end
			if (cmd.load) begin
				match_found_q <= 1'b0;
				zero_found_q  <= 1'b0;
			end else begin
				if (rd_vld_s1 && (cur_ip == ip_q)) begin
					match_found_q <= 1'b1;
				end
				if (rd_vld_s1 && (cur_ip == '0)) begin
					zero_found_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_LOCAL_IP:      local_ip_q  <= cfg_data;
					CFG_REPLY_ENABLED: reply_en_q  <= cfg_data[0];
					CFG_LEARN_TTL:     learn_ttl_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign hit        = hit_q;
	assign found_mac  = found_mac_q;
	assign send_reply = send_reply_q;
	assign reply_ip   = reply_ip_q;
	assign reply_mac  = reply_mac_q;

endmodule

// ----- rtl/arp_cache_with_aging.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// IPv4 to MAC cache with put, lookup, millisecond aging and ARP learning.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low;
// opcode picks put, lookup, tick or received ARP packet, and the remaining
// request ports carry its operands. Every request gives one result: done is
// high for exactly one cycle and hit, found_mac, send_reply, reply_ip and
// reply_mac are valid in that cycle. The receiver cannot stall the block.
// Each request walks the whole table, one entry per cycle through the single
// read port of the table memory, then passes through the drain and finish
// states; busy stays high until done rises, and the result is taken at the
// clock edge that ends the done cycle.
// A new request may be started in the cycle that done is high; requests are
// not overlapped. Configuration registers are written through cfg_we,
// cfg_addr and cfg_data, index 0 local IP, 1 reply enable, 2 learn TTL; the
// user must do so only while the block is idle, which it does not enforce.
// Reset is immediate: the table reads as empty except the static broadcast
// entry at index 0, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_cache_with_aging import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] ip_addr,
	input  logic [47:0] mac_addr,
	input  logic [31:0] time_ms,
	input  logic        static_flag,
	input  logic [15:0] arp_operation,
	input  logic [31:0] dest_ip,
	input  logic [15:0] frame_length,
	output logic        done,
	output logic        hit,
	output logic [47:0] found_mac,
	output logic        send_reply,
	output logic [31:0] reply_ip,
	output logic [47:0] reply_mac
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	arpc_cmd_t        cmd;
	logic [IDX_W-1:0] rd_idx;

	arpc_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.opcode       (opcode),
		.frame_length (frame_length),
		.busy         (busy),
		.done         (done),
		.cmd          (cmd),
		.rd_idx       (rd_idx)
	);

	arpc_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_idx        (rd_idx),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.ip_addr       (ip_addr),
		.mac_addr      (mac_addr),
		.time_ms       (time_ms),
		.static_flag   (static_flag),
		.arp_operation (arp_operation),
		.dest_ip       (dest_ip),
		.frame_length  (frame_length),
		.hit           (hit),
		.found_mac     (found_mac),
		.send_reply    (send_reply),
		.reply_ip      (reply_ip),
		.reply_mac     (reply_mac)
	);

endmodule
